[src/btda_pkg.sv]
// ----------------------------------------------------------------------------
// btda_pkg: shared types and constants for the decimal ascii emitter
// Widths, controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package btda_pkg;

  // field widths
  localparam int ValueW  = 32;
  localparam int AsciiW  = 6;
  localparam int DigitW  = 4;

  // decimal digits needed for the full unsigned 32-bit range
  localparam int NumDigits = 10;
  localparam int BcdW      = NumDigits * DigitW;

  // one double-dabble step per input bit
  localparam int ShiftSteps = ValueW;
  localparam int CntW       = $clog2(ShiftSteps);
  localparam int IdxW       = $clog2(NumDigits);

  localparam logic [CntW-1:0]   LastStep  = CntW'(ShiftSteps - 1);
  localparam logic [IdxW-1:0]   TopIdx    = IdxW'(NumDigits - 1);
  localparam logic [AsciiW-1:0] AsciiZero = AsciiW'(48);
  localparam logic [DigitW-1:0] AdjLimit  = DigitW'(5);
  localparam logic [DigitW-1:0] AdjAdd    = DigitW'(3);

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_FIND,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // take a new value, clear the bcd word
    logic shift;  // one add-3 and shift step
    logic find;   // locate the leading nonzero digit
    logic emit;   // move one digit into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic conv_done;   // final shift step is being done
    logic last_digit;  // digit pointer at the least significant digit
    logic out_free;    // output register can take a digit this cycle
  } sts_t;

endpackage

`default_nettype wire

[src/btda_dp.sv]
// ----------------------------------------------------------------------------
// btda_dp: conversion and output datapath
// Double-dabble shift register, digit pointer and the output register that
// holds one ascii digit until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module btda_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [btda_pkg::ValueW-1:0]     in_value,
  input  wire btda_pkg::cmd_t                  cmd,
  output btda_pkg::sts_t                       sts,
  input  wire logic                            out_stall,
  output logic                                 out_valid,
  output logic [btda_pkg::AsciiW-1:0]          out_ascii_digit,
  output logic                                 out_last
);

  logic [btda_pkg::ValueW-1:0]                         bin_r, bin_nxt;
  logic [btda_pkg::NumDigits-1:0][btda_pkg::DigitW-1:0] bcd_r, bcd_nxt;
  logic [btda_pkg::NumDigits-1:0][btda_pkg::DigitW-1:0] bcd_adj;
  logic [btda_pkg::CntW-1:0]                           cnt_r, cnt_nxt;
  logic [btda_pkg::IdxW-1:0]                           idx_r, idx_nxt;
  logic [btda_pkg::IdxW-1:0]                           lead_idx;
  logic                                                out_valid_r, out_valid_nxt;
  logic [btda_pkg::AsciiW-1:0]                         out_digit_r, out_digit_nxt;
  logic                                                out_last_r, out_last_nxt;
  logic [btda_pkg::DigitW-1:0]                         cur_digit;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int k = 0; k < btda_pkg::NumDigits; k++) begin
      if (bcd_r[k] >= btda_pkg::AdjLimit) begin
        bcd_adj[k] = bcd_r[k] + btda_pkg::AdjAdd;
      end else begin
        bcd_adj[k] = bcd_r[k];
      end
    end
  end

  // highest nonzero digit, or the lowest digit for zero
  always_comb begin
    lead_idx = '0;
    for (int k = 1; k < btda_pkg::NumDigits; k++) begin
      if (bcd_r[k] != '0) begin
        lead_idx = btda_pkg::IdxW'(k);
      end
    end
  end

  assign cur_digit = bcd_r[idx_r];

  // status back to the controller
  assign sts.conv_done  = (cnt_r == btda_pkg::LastStep);
  assign sts.last_digit = (idx_r == '0);
  assign sts.out_free   = !out_valid_r || !out_stall;

  // next values of the conversion registers
  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (cmd.load) begin
      bin_nxt = in_value;
      bcd_nxt = '0;
      cnt_nxt = '0;
    end else if (cmd.shift) begin
      // top bit of the shifted word is always zero for a 32-bit value
      bcd_nxt = btda_pkg::BcdW'({bcd_adj, bin_r[btda_pkg::ValueW-1]});
      bin_nxt = {bin_r[btda_pkg::ValueW-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
    end else if (cmd.find) begin
      idx_nxt = lead_idx;
    end else if (cmd.emit && (idx_r != '0)) begin
      idx_nxt = idx_r - 1'b1;
    end
  end

  // output register: load on emit, drop valid once the transfer is done
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_digit_nxt = out_digit_r;
    out_last_nxt  = out_last_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_digit_nxt = btda_pkg::AsciiZero + btda_pkg::AsciiW'(cur_digit);
      out_last_nxt  = (idx_r == '0);
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bin_r       <= bin_nxt;
    bcd_r       <= bcd_nxt;
    out_digit_r <= out_digit_nxt;
    out_last_r  <= out_last_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ascii_digit = out_digit_r;
  assign out_last        = out_last_r;

  // digit pointer never leaves the bcd word
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= btda_pkg::TopIdx)
    else $error("digit pointer out of range");

  // emit only when the output register is free
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("emit into a full output register");

  // emitting the lowest digit raises last on the output
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && sts.last_digit |=> out_valid_r && out_last_r)
    else $error("last flag missing on final digit");

  // a valid output always holds an ascii decimal digit
  a_ascii_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_digit_r >= btda_pkg::AsciiZero) &&
                    (out_digit_r <= btda_pkg::AsciiZero + btda_pkg::AsciiW'(9)))
    else $error("output digit not in ascii range");

endmodule

`default_nettype wire

[src/btda_ctrl.sv]
// ----------------------------------------------------------------------------
// btda_ctrl: sequencing controller
// Accepts a value, runs the shift steps, finds the leading digit and hands
// digits one by one to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module btda_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire btda_pkg::sts_t  sts,
  output btda_pkg::cmd_t       cmd
);

  btda_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= btda_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      btda_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = btda_pkg::ST_CONV;
        end
      end
      btda_pkg::ST_CONV: begin
        cmd.shift = 1'b1;
        if (sts.conv_done) begin
          state_nxt = btda_pkg::ST_FIND;
        end
      end
      btda_pkg::ST_FIND: begin
        cmd.find  = 1'b1;
        state_nxt = btda_pkg::ST_EMIT;
      end
      btda_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_digit) begin
            state_nxt = btda_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = btda_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[src/binary_to_decimal_ascii_emitter.sv]
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_emitter: unsigned 32-bit number to ascii digits
// Prints one number per input transfer as decimal ascii characters,
// most significant first, no leading zeros, last flag on the final digit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_value carries one unsigned 32-bit
//   number per transfer. Output channel out_valid/out_stall carries one
//   character per transfer on out_ascii_digit, with out_last high on the
//   final character of the number. Zero prints as a single '0'.
//   Timing: the number is accepted, then converted by 32 double-dabble
//   steps (one shift per cycle through the bcd shift register), then
//   the leading digit is found. Characters then follow one per cycle
//   while out_stall is low.
//   in_stall is low only while the controller is idle; the final character
//   may still wait in the output register while the next number is taken.
//   When out_stall is high the output register holds its character and the
//   controller waits. A synchronous reset (rst_n low) returns the
//   controller to idle and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii_emitter (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [btda_pkg::ValueW-1:0]  in_value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [btda_pkg::AsciiW-1:0]       out_ascii_digit,
  output logic                              out_last
);

  btda_pkg::cmd_t cmd;
  btda_pkg::sts_t sts;

  // sequencing
  btda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // conversion and output register
  btda_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_value        (in_value),
    .cmd             (cmd),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_ascii_digit (out_ascii_digit),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

[bench/btda_digit_checker.sv]
// ----------------------------------------------------------------------------
// btda_digit_checker: scoreboard for the decimal ascii emitter
// Watches both channels. Every input transfer is turned into the expected
// run of ascii digits, most significant first, and every output transfer
// is compared field by field with the oldest expected character.
// ----------------------------------------------------------------------------
`default_nettype none

module btda_digit_checker (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic                         in_stall,
  input  wire logic [btda_pkg::ValueW-1:0]  in_value,
  input  wire logic                         out_valid,
  input  wire logic                         out_stall,
  input  wire logic [btda_pkg::AsciiW-1:0]  out_ascii_digit,
  input  wire logic                         out_last,
  input  wire logic                         run_done,
  output int unsigned                       chars_pending,
  output int unsigned                       chars_checked,
  output int unsigned                       fail_count
);

  // one expected character
  typedef struct packed {
    logic [btda_pkg::AsciiW-1:0] ascii;
    logic                        last;
  } exp_char_t;

  exp_char_t exp_chars[$];
  logic      leftover_done = 1'b0;

  initial begin
    chars_pending = 0;
    chars_checked = 0;
    fail_count    = 0;
  end

  // one line per mismatch, and count it
  task automatic report(input string what, input int unsigned want, input int unsigned got);
    $display("mismatch at %0t: %s, expected %0d, got %0d", $realtime, what, want, got);
    fail_count++;
  endtask

  // expected characters of one number, most significant digit first
  function automatic void push_decimal(input logic [btda_pkg::ValueW-1:0] number);
    logic [btda_pkg::ValueW-1:0] rest;
    logic [btda_pkg::DigitW-1:0] digs [btda_pkg::NumDigits];
    exp_char_t                   c;
    int                          n;
    rest = number;
    n    = 0;
    do begin
      digs[n] = btda_pkg::DigitW'(rest % 32'd10);
      n++;
      rest = rest / 32'd10;
    end while (rest != 0 && n < btda_pkg::NumDigits);
    for (int k = n - 1; k >= 0; k--) begin
      c.ascii = btda_pkg::AsciiZero + btda_pkg::AsciiW'(digs[k]);
      c.last  = (k == 0);
      exp_chars.push_back(c);
    end
  endfunction

  // compare output transfers, then predict from input transfers
  always @(posedge clk) begin
    exp_char_t head;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (exp_chars.size() == 0) begin
          report("character with nothing expected", 0, out_ascii_digit);
        end else begin
          head = exp_chars.pop_front();
          if (out_ascii_digit !== head.ascii)
            report("ascii digit", head.ascii, out_ascii_digit);
          if (out_last !== head.last)
            report("last flag", head.last, out_last);
          chars_checked <= chars_checked + 1;
        end
      end
      if (in_valid && !in_stall)
        push_decimal(in_value);
      if (run_done && !leftover_done) begin
        leftover_done <= 1'b1;
        if (exp_chars.size() != 0)
          report("characters never emitted", 0, exp_chars.size());
      end
    end
    chars_pending <= exp_chars.size();
  end

endmodule

`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: top level bench for the decimal ascii emitter
// Drives numbers into the block under four idle mixes, with directed edge
// values first and then random values spread over all digit counts. The
// checker beside the block predicts and compares; this module only makes
// stimulus, runs a watchdog and gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int QuietLimit = 4000;
  localparam int ItemsPerMix = 56;
  localparam int TailCycles = 60;

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic [btda_pkg::ValueW-1:0] in_value  = '0;
  logic                        out_stall = 1'b0;
  logic                        run_done  = 1'b0;
  wire logic                        in_stall;
  wire logic                        out_valid;
  wire logic [btda_pkg::AsciiW-1:0] out_ascii_digit;
  wire logic                        out_last;
  int unsigned       chars_pending;
  int unsigned       chars_checked;
  int unsigned       fail_count;

  int          send_idle_pct  = 0;
  int          stall_pct      = 0;
  int unsigned numbers_sent   = 0;
  int unsigned ten_digit_seen = 0;
  int unsigned quiet_cycles   = 0;

  // idle mixes: none, sender only, receiver only, both lightly
  int mix_send  [4] = '{0, 74, 0, 13};
  int mix_stall [4] = '{0, 0, 74, 13};

  binary_to_decimal_ascii_emitter i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ascii_digit (out_ascii_digit),
    .out_last        (out_last)
  );

  btda_digit_checker i_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ascii_digit (out_ascii_digit),
    .out_last        (out_last),
    .run_done        (run_done),
    .chars_pending   (chars_pending),
    .chars_checked   (chars_checked),
    .fail_count      (fail_count)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // one number through the input channel, with random idle cycles ahead
  task automatic send_number(input logic [btda_pkg::ValueW-1:0] number);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= number;
    numbers_sent++;
    if (number >= 32'd1000000000)
      ten_digit_seen++;
    do @(posedge clk); while (in_stall);
  endtask

  // hold the sender until every expected character has come out
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
  endtask

  // random number, weighted toward all digit counts and inner zeros
  function automatic logic [btda_pkg::ValueW-1:0] pick_number();
    longint unsigned p;
    longint unsigned acc;
    int              ndig;
    p   = 1;
    acc = 0;
    ndig = $urandom_range(10, 1);
    case ($urandom_range(3))
      0: begin
        return $urandom();
      end
      1: begin
        for (int i = 1; i < ndig; i++) p = p * 10;
        if (ndig == 10) return $urandom_range(32'hFFFF_FFFF, 32'd1000000000);
        return $urandom_range(32'(p * 10 - 1), 32'(p));
      end
      2: begin
        for (int i = 1; i < ndig; i++) p = p * 10;
        if ($urandom_range(1)) return btda_pkg::ValueW'(p + $urandom_range(2) - 1);
        return 32'hFFFF_FFFF - $urandom_range(20);
      end
      default: begin
        acc = $urandom_range(9, 1);
        for (int i = 1; i < ndig; i++)
          acc = acc * 10 + ($urandom_range(1) ? 0 : $urandom_range(9));
        return btda_pkg::ValueW'(acc);
      end
    endcase
  endfunction

  // stimulus and verdict
  initial begin
    logic [btda_pkg::ValueW-1:0] edge_vals [$];
    edge_vals = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd101,
                  32'd10000, 32'd999999999, 32'd1000000000, 32'd1000000007,
                  32'd1234567890, 32'd2147483647, 32'd2147483648,
                  32'd4000000000, 32'd4294967294, 32'hFFFF_FFFF,
                  32'hAAAA_AAAA, 32'h5555_5555, 32'd0, 32'd7};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed edge values, light idling on both sides
    send_idle_pct = mix_send[3];
    stall_pct     = mix_stall[3];
    foreach (edge_vals[i]) send_number(edge_vals[i]);
    drain();

    // random numbers, two passes over the idle mixes
    for (int pass = 0; pass < 2; pass++) begin
      for (int m = 0; m < 4; m++) begin
        send_idle_pct = mix_send[m];
        stall_pct     = mix_stall[m];
        repeat (ItemsPerMix) send_number(pick_number());
        drain();
      end
    end

    stall_pct = 0;
    drain();
    repeat (TailCycles) @(posedge clk);
    run_done <= 1'b1;
    repeat (3) @(posedge clk);

    $display("covered %0d numbers (%0d of ten digits) and %0d characters",
             numbers_sent, ten_digit_seen, chars_checked);
    $display("idle mixes: none, sender only, receiver only, both sides");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
src/btda_pkg.sv
src/btda_dp.sv
src/btda_ctrl.sv
src/binary_to_decimal_ascii_emitter.sv
bench/btda_digit_checker.sv
bench/tb.sv
